FILE: rtl/core/fwl_pkg.sv
// -----------------------------------------------------------------------------
// fwl_pkg
// Register map, reset values and shared types of the failure window lockout.
// -----------------------------------------------------------------------------
package fwl_pkg;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   // register index, taken from paddr bit 2
   localparam logic REG_WINDOW_MS = 1'b0;
   localparam logic REG_BLOCK_MS  = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] WINDOW_MS_RESET = 32'd60000;
   localparam logic [CSR_DATA_BITS-1:0] BLOCK_MS_RESET  = 32'd300000;

   localparam int RSP_DATA_BITS = 8;

   typedef struct packed {
      logic lockout_started;
      logic locked_out;
      logic granted;
   } verdict_type;

endpackage

FILE: rtl/core/failure_window_lockout.sv
// -----------------------------------------------------------------------------
// failure_window_lockout
// Sliding-window lockout after repeated failed authentication attempts.
// -----------------------------------------------------------------------------
//
//   channel  | direction | beat contents
//   ---------+-----------+-----------------------------------------------
//   req_*    | in        | one attempt: now_ms, credential_ok
//   rsp_*    | out       | one verdict: granted, locked_out, lockout_started
//   csr_*    | in/out    | APB registers window_ms (0x0), block_ms (0x4)
//
// Each attempt passes through the input register and then the result
// register; one attempt is accepted per cycle while rsp_tready does not stall.
// The history shift, the window subtraction and the saturating expiry add sit
// between the two registers and set the clock rate.
// Reset (synchronous, active high) empties the history, drops any lockout and
// restores the register defaults. A stalled rsp_tready holds the result and,
// once the input register is also full, drops req_tready.
// -----------------------------------------------------------------------------
module failure_window_lockout
   import fwl_pkg::*;
#(
   parameter int FAIL_LIMIT = 5,
   parameter int TIME_BITS  = 48,
   localparam int REQ_DATA_BITS = ((TIME_BITS + 1 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // req_tdata: now_ms [TIME_BITS-1:0], credential_ok [TIME_BITS], zero pad
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // rsp_tdata: granted [0], locked_out [1], lockout_started [2], zero pad
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // configuration registers
   logic [CSR_DATA_BITS-1:0] window_ms_ff;
   logic [CSR_DATA_BITS-1:0] block_ms_ff;
   logic                     csr_write;

   // input register
   logic                 s1_valid_ff;
   logic [TIME_BITS-1:0] s1_now_ff;
   logic                 s1_ok_ff;
   logic                 s1_fire;

   // block state
   logic [TIME_BITS-1:0] fail_times_ff [FAIL_LIMIT];
   logic [TIME_BITS-1:0] fail_times_in [FAIL_LIMIT];
   logic [FAIL_LIMIT-1:0] fail_valid_ff;
   logic [FAIL_LIMIT-1:0] fail_valid_in;
   logic [TIME_BITS-1:0] lock_expiry_ff;
   logic [TIME_BITS-1:0] lock_expiry_in;
   logic                 lock_active_ff;
   logic                 lock_active_in;

   // result register
   logic        rsp_valid_ff;
   verdict_type verdict_ff;
   verdict_type verdict_in;

   // datapath
   logic                 running;
   logic [FAIL_LIMIT-1:0] base_valid;
   logic [TIME_BITS-1:0] delta;
   logic                 trigger;
   logic [TIME_BITS:0]   expiry_sum;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= WINDOW_MS_RESET;
         block_ms_ff  <= BLOCK_MS_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_WINDOW_MS: window_ms_ff <= csr_pwdata;
            REG_BLOCK_MS:  block_ms_ff  <= csr_pwdata;
            default:       window_ms_ff <= window_ms_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WINDOW_MS: csr_prdata = window_ms_ff;
         REG_BLOCK_MS:  csr_prdata = block_ms_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ input stage
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_now_ff <= req_tdata[TIME_BITS-1:0];
         s1_ok_ff  <= req_tdata[TIME_BITS];
      end
   end

   // ------------------------------------------------------------- decision
   always_comb begin
      running        = lock_active_ff && (lock_expiry_ff > s1_now_ff);
      verdict_in     = '0;
      fail_valid_in  = fail_valid_ff;
      lock_expiry_in = lock_expiry_ff;
      lock_active_in = lock_active_ff;
      for (int i = 0; i < FAIL_LIMIT; i++) begin
         fail_times_in[i] = fail_times_ff[i];
      end

      // an expired lockout takes the history with it on the next fail
      base_valid = lock_active_ff ? '0 : fail_valid_ff;
      delta      = s1_now_ff - fail_times_ff[FAIL_LIMIT-2];
      trigger    = base_valid[FAIL_LIMIT-2] && (delta < TIME_BITS'(window_ms_ff));
      expiry_sum = (TIME_BITS+1)'(s1_now_ff) + (TIME_BITS+1)'(block_ms_ff);

      if (running) begin
         verdict_in.locked_out = 1'b1;
      end else if (s1_ok_ff) begin
         verdict_in.granted = 1'b1;
      end else begin
         fail_times_in[0] = s1_now_ff;
         for (int i = 1; i < FAIL_LIMIT; i++) begin
            fail_times_in[i] = fail_times_ff[i-1];
         end
         fail_valid_in = {base_valid[FAIL_LIMIT-2:0], 1'b1};
         lock_active_in = 1'b0;
         lock_expiry_in = '0;
         if (trigger) begin
            verdict_in.lockout_started = 1'b1;
            fail_valid_in  = '0;
            lock_active_in = 1'b1;
            // saturate at the top of the time range
            lock_expiry_in = expiry_sum[TIME_BITS] ? TIME_MAX : expiry_sum[TIME_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_valid_ff  <= '0;
         lock_active_ff <= 1'b0;
         lock_expiry_ff <= '0;
      end else if (s1_fire) begin
         fail_valid_ff  <= fail_valid_in;
         lock_active_ff <= lock_active_in;
         lock_expiry_ff <= lock_expiry_in;
      end
   end

   // timestamps are only read behind their valid bit
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         for (int i = 0; i < FAIL_LIMIT; i++) begin
            fail_times_ff[i] <= fail_times_in[i];
         end
      end
   end

   // ----------------------------------------------------------- result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-3){1'b0}}, verdict_ff};

   // ------------------------------------------------------------- assertions
   a_verdict_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0(verdict_ff))
      else $error("more than one verdict flag set");

   a_start_arms_lock: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && verdict_in.lockout_started) |=> (lock_active_ff && fail_valid_ff == '0))
      else $error("lockout started without arming lock and clearing history");

   a_deny_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !verdict_in.lockout_started && verdict_in.locked_out)
         |=> ($stable(fail_valid_ff) && $stable(lock_expiry_ff) && lock_active_ff))
      else $error("denied attempt changed the state");

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

endmodule
